// ----- hdl/stbs_pkg.sv -----
// Shared constants and types for the sorted table binary search block.
package stbs_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int IDX_W       = 10;
   localparam int DATA_W      = 32;
   // signed search bounds: low may reach 1024, high may drop to -1
   localparam int BND_W       = IDX_W + 2;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } tbl_req_type;

endpackage

// ----- hdl/sorted_table_binary_search.sv -----
// Writes: a write transfer is stored in the cycle it is taken; one write per cycle while no search is running.
// Search: each probe issues a table read in ST_CHECK and compares in ST_CMP; ST_DONE then
//   loads the result, with up to 11 probes over 1024 entries on the single read port.
// Throughput: one search at a time; the next transfer is taken after the result is loaded.
// Reset: synchronous, clears the sequencer and result valid; table contents stay
//   undefined until written, with no clearing pass.
module sorted_table_binary_search
   import stbs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_operation,
   input  logic [IDX_W-1:0]         req_entry_index,
   input  logic signed [DATA_W-1:0] req_data_value,
   input  logic [IDX_W-1:0]         req_range_low,
   input  logic [IDX_W-1:0]         req_range_high,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_found
);

   // Writes happen only while idle and reads only during a search,
   // so the two ports never touch the same entry in one cycle.
   tbl_req_type       tbl_req;
   logic [DATA_W-1:0] tbl_rd_data;

   // Sequencer: bounds, midpoint, compare, and the result register that
   // lets a write transfer in while a result waits on rsp_stall.
   stbs_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_entry_index (req_entry_index),
      .req_data_value  (req_data_value),
      .req_range_low   (req_range_low),
      .req_range_high  (req_range_high),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .tbl_req         (tbl_req),
      .tbl_rd_data     (tbl_rd_data)
   );

   // Entry store with registered read data.
   stbs_table u_table (
      .clock   (clock),
      .tbl_req (tbl_req),
      .rd_data (tbl_rd_data)
   );

endmodule

// ----- hdl/stbs_table.sv -----
// Entry table: one write port, one read port, registered read data.
module stbs_table
   import stbs_pkg::*;
(
   input  logic              clock,
   input  tbl_req_type       tbl_req,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [TABLE_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (tbl_req.wr_en) begin
         mem[tbl_req.wr_addr] <= tbl_req.wr_data;
      end
      if (tbl_req.rd_en) begin
         rd_data_ff <= mem[tbl_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/stbs_ctrl.sv -----
// Search sequencer: takes transfers, walks the probe loop, holds the result register.
module stbs_ctrl
   import stbs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_operation,
   input  logic [IDX_W-1:0]         req_entry_index,
   input  logic signed [DATA_W-1:0] req_data_value,
   input  logic [IDX_W-1:0]         req_range_low,
   input  logic [IDX_W-1:0]         req_range_high,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_found,
   output tbl_req_type              tbl_req,
   input  logic [DATA_W-1:0]        tbl_rd_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_CMP,
      ST_DONE
   } state_type;

   state_type                state_ff;
   logic signed [BND_W-1:0]  lo_ff;
   logic signed [BND_W-1:0]  hi_ff;
   logic signed [BND_W-1:0]  mid_ff;
   logic signed [DATA_W-1:0] key_ff;
   logic                     oob_ff;
   logic                     found_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_found_ff;

   logic signed [BND_W-1:0]  span;
   logic signed [BND_W-1:0]  mid_in;
   logic                     range_empty;
   logic                     mid_in_table;
   logic                     wr_in_table;
   logic signed [DATA_W-1:0] entry;
   logic                     hit;
   logic                     greater;
   logic                     rsp_free;
   logic                     take;

   assign span         = hi_ff - lo_ff;
   assign mid_in       = lo_ff + (span >>> 1);
   assign range_empty  = lo_ff > hi_ff;
   assign mid_in_table = int'(mid_in) < TABLE_DEPTH;
   assign wr_in_table  = int'(req_entry_index) < TABLE_DEPTH;
   // probes past the table end read as zero
   assign entry        = oob_ff ? '0 : $signed(tbl_rd_data);
   assign hit          = entry == key_ff;
   assign greater      = entry > key_ff;
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign take         = req_valid && (state_ff == ST_IDLE);

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;

   always_comb begin
      tbl_req.wr_en   = take && (req_operation == OP_WRITE) && wr_in_table;
      tbl_req.wr_addr = ADDR_W'(req_entry_index);
      tbl_req.wr_data = req_data_value;
      tbl_req.rd_en   = (state_ff == ST_CHECK) && !range_empty;
      tbl_req.rd_addr = ADDR_W'($unsigned(mid_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // load a new result, or drop the one just taken
         if ((state_ff == ST_DONE) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (take && (req_operation == OP_SEARCH)) begin
                  lo_ff    <= BND_W'(req_range_low);
                  hi_ff    <= BND_W'(req_range_high);
                  key_ff   <= req_data_value;
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (range_empty) begin
                  found_ff <= 1'b0;
                  state_ff <= ST_DONE;
               end else begin
                  mid_ff   <= mid_in;
                  oob_ff   <= !mid_in_table;
                  state_ff <= ST_CMP;
               end
            end
            ST_CMP: begin
               if (hit) begin
                  found_ff <= 1'b1;
                  state_ff <= ST_DONE;
               end else begin
                  if (greater) begin
                     hi_ff <= mid_ff - BND_W'(1);
                  end else begin
                     lo_ff <= mid_ff + BND_W'(1);
                  end
                  state_ff <= ST_CHECK;
               end
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_found_ff <= found_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // a compare always follows its own read issue
   a_cmp_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> $past(tbl_req.rd_en))
      else $error("compare without a read issued");

   // probe index stays inside the live bounds
   a_mid_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (lo_ff <= mid_ff) && (mid_ff <= hi_ff))
      else $error("probe outside search bounds");

   // every miss shrinks the range
   a_range_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) && $past(state_ff == ST_CMP) |-> span < $past(span))
      else $error("search range did not shrink");

   // a result appears only at the end of a search
   a_rsp_from_search: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result without a finished search");

endmodule

// ----- bench/sorted_table_binary_search_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for sorted_table_binary_search: table writes and range searches.
module sorted_table_binary_search_tb
   import stbs_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 2000;   // idle cycles with no transfer on either side
   localparam int SETTLE_CYCLES  = 40;     // margin above the worst-case search
   localparam int ITEM_TARGET    = 750;
   localparam int MAX_REPORTS    = 10;
   localparam int CALM_FIRST     = 250;    // transfers window with no idling at all
   localparam int CALM_LAST      = 420;
   localparam bit signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam bit signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      logic                     op;
      logic [IDX_W-1:0]         index;
      logic signed [DATA_W-1:0] value;
      logic [IDX_W-1:0]         lo;
      logic [IDX_W-1:0]         hi;
   } table_op_type;

   // DUT ports, all known from time zero
   logic                     clock           = 1'b0;
   logic                     reset           = 1'b1;
   logic                     req_valid       = 1'b0;
   logic                     req_stall;
   logic                     req_operation   = OP_WRITE;
   logic [IDX_W-1:0]         req_entry_index = '0;
   logic signed [DATA_W-1:0] req_data_value  = '0;
   logic [IDX_W-1:0]         req_range_low   = '0;
   logic [IDX_W-1:0]         req_range_high  = '0;
   logic                     rsp_valid;
   logic                     rsp_stall       = 1'b0;
   logic                     rsp_found;

   // Stimulus plan: table image as the generator sees it, ahead of the block.
   // Used to keep every search on entries that were written first.
   bit signed [DATA_W-1:0] plan_tbl [TABLE_DEPTH];
   bit                     plan_wr  [TABLE_DEPTH];
   // Predictor state, advanced only on accepted transfers.
   bit signed [DATA_W-1:0] model_tbl [TABLE_DEPTH];

   table_op_type table_ops[$];       // items waiting for the driver
   bit        expected_found[$];  // one entry per accepted search
   int        planned      = 0;
   int        ops_taken    = 0;
   int        writes_taken = 0;
   int        searches_taken = 0;
   int        results_seen = 0;
   int        hits_seen    = 0;
   int        errors       = 0;
   int        quiet_cycles = 0;
   bit        want;
   logic      calm;

   assign calm = (ops_taken >= CALM_FIRST) && (ops_taken < CALM_LAST);

   always #4 clock = ~clock;

   sorted_table_binary_search u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_entry_index (req_entry_index),
      .req_data_value  (req_data_value),
      .req_range_low   (req_range_low),
      .req_range_high  (req_range_high),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found)
   );

   // Halving walk over the inclusive range [first, last]. Probes the midpoint,
   // stops on equality, keeps the lower half when the entry is above the key.
   // The range empties when the bounds cross, including high dropping below 0.
   // On the plan image it also reports whether every probe hit a written entry.
   function automatic bit bsearch_walk(input bit on_plan,
                                       input bit signed [DATA_W-1:0] key,
                                       input int first, input int last,
                                       output bit clean);
      int lo, hi, mid;
      bit signed [DATA_W-1:0] probed;
      bit hit;
      lo    = first;
      hi    = last;
      hit   = 1'b0;
      clean = 1'b1;
      while (lo <= hi && !hit) begin
         mid    = lo + (hi - lo) / 2;
         probed = on_plan ? plan_tbl[mid] : model_tbl[mid];
         if (on_plan && !plan_wr[mid]) clean = 1'b0;
         if (probed == key) hit = 1'b1;
         else if (probed > key) hi = mid - 1;
         else lo = mid + 1;
      end
      return hit;
   endfunction

   task automatic queue_write(input int index, input bit signed [DATA_W-1:0] value);
      table_op_type t;
      t.op    = OP_WRITE;
      t.index = index[IDX_W-1:0];
      t.value = value;
      t.lo    = IDX_W'($urandom);   // range fields are don't-care on a write
      t.hi    = IDX_W'($urandom);
      plan_tbl[index] = value;
      plan_wr[index]  = 1'b1;
      table_ops.push_back(t);
      planned++;
   endtask

   task automatic queue_search(input bit signed [DATA_W-1:0] key, input int lo, input int hi);
      table_op_type t;
      t.op    = OP_SEARCH;
      t.index = IDX_W'($urandom);   // entry index is don't-care on a search
      t.value = key;
      t.lo    = lo[IDX_W-1:0];
      t.hi    = hi[IDX_W-1:0];
      table_ops.push_back(t);
      planned++;
   endtask

   // Predictor: runs on the transfer held on the request ports at acceptance.
   task automatic apply_table_op();
      bit unused;
      if (req_operation == OP_WRITE) begin
         // index is 10 bits, so it always lands inside the 1024-entry table
         model_tbl[req_entry_index] = req_data_value;
      end else begin
         expected_found.push_back(bsearch_walk(1'b0, req_data_value,
                                               int'(req_range_low), int'(req_range_high),
                                               unused));
      end
   endtask

   // Driver: a new transfer loads only when the current one has gone or none is up.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_table_op();
            ops_taken <= ops_taken + 1;
            if (req_operation == OP_WRITE) writes_taken <= writes_taken + 1;
            else searches_taken <= searches_taken + 1;
         end
         if (!req_valid || !req_stall) begin
            if (table_ops.size() != 0 && (calm || $urandom_range(99) >= 30)) begin
               req_operation   <= table_ops[0].op;
               req_entry_index <= table_ops[0].index;
               req_data_value  <= table_ops[0].value;
               req_range_low   <= table_ops[0].lo;
               req_range_high  <= table_ops[0].hi;
               req_valid       <= 1'b1;
               void'(table_ops.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: every accepted result is matched against the oldest expected flag.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_found.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("[%0t] result with no search pending: found=%b", $realtime, rsp_found);
            end else begin
               want = expected_found.pop_front();
               if (rsp_found !== want) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display("[%0t] found mismatch: expected %b, got %b",
                              $realtime, want, rsp_found);
               end
            end
            results_seen <= results_seen + 1;
            if (rsp_found === 1'b1) hits_seen <= hits_seen + 1;
         end
         rsp_stall <= !calm && ($urandom_range(99) < 30);
      end
   end

   // Watchdog: a hang shows up as a long run of cycles with no transfer at all.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d cycles with no transfer", quiet_cycles);
            $display("sorted_table_binary_search regression: fail");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      int run_len, base, lo, hi, tries, n_search, pick;
      longint acc, step_max;
      bit signed [DATA_W-1:0] key;
      bit clean;

      // ---- directed part ----
      // Sorted low block, with duplicates; entry 0 sits one above the most
      // negative value so a key below it drives the upper bound under zero.
      queue_write(0, -32'sd2147483647);
      queue_write(1, -32'sd1000);
      queue_write(2, -32'sd5);
      queue_write(3, 32'sd0);
      queue_write(4, 32'sd3);
      queue_write(5, 32'sd3);
      queue_write(6, 32'sd100);
      queue_write(7, 32'sd2000);
      // Entries on the probe path of a full-range descent to index 0
      queue_write(15, 32'sd5000);
      queue_write(31, 32'sd70000);
      queue_write(63, 32'sd1 <<< 20);
      queue_write(127, 32'sd1 <<< 24);
      queue_write(255, 32'sd1 <<< 28);
      queue_write(511, 32'sd1 <<< 30);
      queue_write(1023, VAL_MAX);
      queue_search(VAL_MIN, 0, 7);                 // below everything: bound falls under 0
      queue_search(-32'sd2147483647, 0, 1023);     // full range, found at the last probe
      queue_search(32'sd1 <<< 30, 0, 1023);        // full range, found at the first probe
      queue_search(VAL_MAX, 1023, 1023);           // top index, single-entry range
      queue_search(32'sd0, 5, 3);                  // empty range, nothing probed
      queue_search(32'sd3, 0, 7);                  // duplicate key
      queue_search(32'sd50, 0, 7);                 // key falls between entries
      queue_write(2, 32'sd999999);                 // breaks the ordering
      queue_search(32'sd999999, 0, 7);             // walk misses the out-of-order entry

      // ---- random part ----
      while (planned < ITEM_TARGET) begin
         if ($urandom_range(99) < 70) begin
            // Well-formed: an ascending run of writes, then searches inside it
            run_len  = ($urandom_range(9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
            base     = $urandom_range(0, TABLE_DEPTH - run_len);
            case ($urandom_range(3))
               0:       step_max = 3;
               1:       step_max = 1000;
               2:       step_max = 1 << 20;
               default: step_max = 1 << 27;
            endcase
            acc = ($urandom_range(9) == 0) ? longint'(VAL_MIN) : longint'($signed($urandom));
            for (int i = 0; i < run_len; i++) begin
               queue_write(base + i, acc[DATA_W-1:0]);
               acc += longint'($urandom_range(0, int'(step_max)));
               if (acc > longint'(VAL_MAX)) acc = longint'(VAL_MAX);   // saturate: dupes at top
            end
            n_search = $urandom_range(1, 6);
            for (int s = 0; s < n_search; s++) begin
               lo   = $urandom_range(1) ? base : base + $urandom_range(0, run_len - 1);
               hi   = $urandom_range(1) ? base + run_len - 1
                                        : lo + $urandom_range(0, base + run_len - 1 - lo);
               pick = $urandom_range(9);
               if (pick < 4)
                  key = plan_tbl[lo + $urandom_range(0, hi - lo)];
               else if (pick < 6)
                  key = plan_tbl[lo + $urandom_range(0, hi - lo)] + ($urandom_range(1) ? 1 : -1);
               else
                  key = $urandom;
               if ($urandom_range(19) == 0 && lo > 0) hi = lo - 1;   // empty range
               queue_search(key, lo, hi);
            end
         end else if ($urandom_range(1)) begin
            // Noise: a stray write anywhere, usually breaking some ordering
            queue_write($urandom_range(0, TABLE_DEPTH - 1), $urandom);
         end else begin
            // Noise: an arbitrary search, kept only if every probe lands on a written entry
            clean = 1'b0;
            tries = 0;
            while (!clean && tries < 20) begin
               lo  = $urandom_range(0, TABLE_DEPTH - 1);
               hi  = ($urandom_range(3) == 0) ? $urandom_range(lo, TABLE_DEPTH - 1)
                                              : lo + $urandom_range(0, 63);
               if (hi > TABLE_DEPTH - 1) hi = TABLE_DEPTH - 1;
               key = $urandom_range(1) ? plan_tbl[$urandom_range(lo, hi)] : $signed($urandom);
               void'(bsearch_walk(1'b1, key, lo, hi, clean));
               tries++;
            end
            if (!clean) begin
               lo = $urandom_range(1, TABLE_DEPTH - 1);
               hi = $urandom_range(0, lo - 1);
            end
            queue_search(key, lo, hi);
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Drain: sampled on the falling edge, clear of the rising-edge updates
      while (table_ops.size() != 0 || req_valid || expected_found.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d table writes and %0d searches, %0d results (%0d found, %0d missed)",
               writes_taken, searches_taken, results_seen, hits_seen, results_seen - hits_seen);
      $display("mismatches: %0d, extremes, empty ranges, unsorted walks and a no-idle stretch",
               errors);
      if (errors == 0) begin
         $display("sorted_table_binary_search regression: pass");
      end else begin
         $display("sorted_table_binary_search regression: fail");
      end
      $finish;
   end

endmodule
